@@ rtl/core/sidt_pkg.sv @@
// Shared definitions for the sorted key table: operation and status codes,
// fixed field widths and the flag group passed out of the search step unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sidt_pkg;

    // Operation codes carried on the input tuser.
    localparam logic [1:0] MODE_ALLOC  = 2'd0;
    localparam logic [1:0] MODE_MARK   = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;
    localparam logic [1:0] MODE_NEWF   = 2'd3;

    // Result status codes carried on the output tuser.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    // Fixed widths of the stream fields.
    localparam int KEY_IN_W    = 16;
    localparam int SLOT_OUT_W  = 6;
    localparam int CNT_OUT_W   = 7;
    localparam int TDATA_OUT_W = 24;

    // Flags from one binary search step.
    typedef struct packed {
        logic in_range;  // lower bound still below upper bound
        logic hit;       // probed key equals the target
        logic below;     // probed key is less than the target
    } cmp_flags_t;

endpackage

`default_nettype wire

@@ rtl/core/sorted_id_table_with_completion.sv @@
// A lookup or mark makes at most ceil(log2(entries + 1)) binary search
// probes; an allocation also moves order list entries and a new frame
// clears the written bit of every entry. One transfer at a time: s_tready is
// high only while idle. Reset (aresetn low, synchronous) empties the table
// and clears the counters.
`timescale 1ns / 1ps
`default_nettype none

module sorted_id_table_with_completion
    import sidt_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    parameter int KEY_BITS    = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Input channel.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [KEY_IN_W-1:0]    s_tdata,  // [15:0] key
    input  wire logic [1:0]             s_tuser,  // [1:0] mode
    // Result channel.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [5:0] slot, [6] was_written, [13:7] entry_total, [20:14] clean_left,
    // [21] frame_complete, [23:22] zero
    output logic [TDATA_OUT_W-1:0]      m_tdata,
    output logic [1:0]                  m_tuser   // [1:0] status
);

    // Index width addresses one entry; count width holds the full count.
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ENTRIES);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PROBE  = 4'd1;
    localparam logic [3:0] S_SLOT   = 4'd2;
    localparam logic [3:0] S_CMP    = 4'd3;
    localparam logic [3:0] S_DECIDE = 4'd4;
    localparam logic [3:0] S_EXEC   = 4'd5;
    localparam logic [3:0] S_SHIFT  = 4'd6;
    localparam logic [3:0] S_PLACE  = 4'd7;
    localparam logic [3:0] S_CLEAR  = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    // Table memories: the order list holds slot numbers sorted by key, the
    // key store holds the key of each slot and the written store one bit per
    // slot. Only allocated slots are ever read, and allocation writes them.
    logic [IW-1:0]       order_mem [MAX_ENTRIES];
    logic [KEY_BITS-1:0] key_mem   [MAX_ENTRIES];
    logic                wb_mem    [MAX_ENTRIES];

    logic [IW-1:0]       order_q;
    logic [KEY_BITS-1:0] key_q;
    logic                wb_q;

    logic                ord_we;
    logic [IW-1:0]       ord_waddr;
    logic [IW-1:0]       ord_wdata;
    logic [IW-1:0]       ord_raddr;
    logic                key_we;
    logic [IW-1:0]       key_raddr;
    logic                wb_we;
    logic [IW-1:0]       wb_waddr;
    logic                wb_wdata;

    // Control state.
    logic [3:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       clean_reg, clean_next;
    logic                complete_reg, complete_next;
    logic                m_tvalid_reg, m_tvalid_next;

    // Per-transfer working registers.
    logic [1:0]          mode_reg, mode_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [CW-1:0]       lo_reg, lo_next;
    logic [CW-1:0]       hi_reg, hi_next;
    logic                hit_reg, hit_next;
    logic [IW-1:0]       slot_reg, slot_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [IW-1:0]       dst_reg, dst_next;
    logic                pend_reg, pend_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic [IW-1:0]       res_slot_reg, res_slot_next;
    logic                res_wr_reg, res_wr_next;

    // Output payload registers.
    logic [TDATA_OUT_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]             m_tuser_reg, m_tuser_next;

    logic [KEY_BITS-1:0] key_in;
    logic [CW-1:0]       mid;
    logic [CW-1:0]       lo_step;
    logic [CW-1:0]       hi_step;
    cmp_flags_t          flags;
    logic [CW-1:0]       clean_dec;

    // Key bits above KEY_BITS are dropped; narrower inputs are zero extended.
    assign key_in = KEY_BITS'(s_tdata);

    // The one compare and bound update unit, reused on every probe.
    sidt_step_unit #(
        .CW       (CW),
        .KEY_BITS (KEY_BITS)
    ) u_step (
        .lo         (lo_reg),
        .hi         (hi_reg),
        .probe_key  (key_q),
        .target_key (key_reg),
        .mid        (mid),
        .lo_new     (lo_step),
        .hi_new     (hi_step),
        .flags      (flags)
    );

    // The clean count saturates at zero.
    assign clean_dec = (clean_reg != '0) ? clean_reg - CW'(1) : '0;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        clean_next      = clean_reg;
        complete_next   = complete_reg;
        m_tvalid_next   = m_tvalid_reg;
        mode_next       = mode_reg;
        key_next        = key_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        pos_next        = pos_reg;
        j_next          = j_reg;
        dst_next        = dst_reg;
        pend_next       = pend_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_wr_next     = res_wr_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        ord_we    = 1'b0;
        ord_waddr = dst_reg;
        ord_wdata = order_q;
        ord_raddr = mid[IW-1:0];
        key_we    = 1'b0;
        key_raddr = order_q;
        wb_we     = 1'b0;
        wb_waddr  = slot_reg;
        wb_wdata  = 1'b0;

        // The consumer taking a result frees the output register.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    mode_next = s_tuser;
                    key_next  = key_in;
                    lo_next   = '0;
                    hi_next   = count_reg;
                    hit_next  = 1'b0;
                    j_next    = '0;
                    state_next = (s_tuser == MODE_NEWF) ? S_CLEAR : S_PROBE;
                end
            end

            S_PROBE: begin
                // Fetch the slot at the middle of the window, or stop on a miss.
                ord_raddr = mid[IW-1:0];
                state_next = flags.in_range ? S_SLOT : S_DECIDE;
            end

            S_SLOT: begin
                key_raddr  = order_q;
                slot_next  = order_q;
                state_next = S_CMP;
            end

            S_CMP: begin
                if (flags.hit) begin
                    hit_next   = 1'b1;
                    state_next = S_DECIDE;
                end else begin
                    lo_next    = lo_step;
                    hi_next    = hi_step;
                    state_next = S_PROBE;
                end
            end

            S_DECIDE: begin
                // The written store is read for the slot found.
                state_next = S_EXEC;
            end

            S_EXEC: begin
                res_status_next = ST_OK;
                res_slot_next   = slot_reg;
                res_wr_next     = wb_q;
                state_next      = S_OUT;
                if (!hit_reg) begin
                    res_slot_next = '0;
                    res_wr_next   = 1'b0;
                    if (mode_reg != MODE_ALLOC) begin
                        res_status_next = ST_ABSENT;
                    end else if (count_reg >= MAX_COUNT) begin
                        res_status_next = ST_FULL;
                    end else begin
                        // Open a gap at the insertion point, top entry first.
                        slot_next  = count_reg[IW-1:0];
                        pos_next   = lo_reg;
                        j_next     = count_reg;
                        pend_next  = 1'b0;
                        state_next = S_SHIFT;
                    end
                end else if (mode_reg == MODE_MARK && !wb_q) begin
                    wb_we         = 1'b1;
                    wb_waddr      = slot_reg;
                    wb_wdata      = 1'b1;
                    res_wr_next   = 1'b1;
                    clean_next    = clean_dec;
                    if (clean_dec == '0) begin
                        complete_next = 1'b1;
                    end
                end
            end

            S_SHIFT: begin
                // Each cycle writes the entry read in the cycle before and
                // reads the next one down.
                if (pend_reg) begin
                    ord_we    = 1'b1;
                    ord_waddr = dst_reg;
                    ord_wdata = order_q;
                end
                if (j_reg != pos_reg) begin
                    ord_raddr = IW'(j_reg - CW'(1));
                    dst_next  = j_reg[IW-1:0];
                    j_next    = j_reg - CW'(1);
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = S_PLACE;
                    end
                end
            end

            S_PLACE: begin
                ord_we          = 1'b1;
                ord_waddr       = pos_reg[IW-1:0];
                ord_wdata       = slot_reg;
                key_we          = 1'b1;
                wb_we           = 1'b1;
                wb_waddr        = slot_reg;
                wb_wdata        = 1'b0;
                count_next      = count_reg + CW'(1);
                res_status_next = ST_OK;
                res_slot_next   = slot_reg;
                res_wr_next     = 1'b0;
                state_next      = S_OUT;
            end

            S_CLEAR: begin
                // Only allocated slots need clearing; new slots are cleared
                // when they are handed out.
                if (j_reg != count_reg) begin
                    wb_we    = 1'b1;
                    wb_waddr = j_reg[IW-1:0];
                    wb_wdata = 1'b0;
                    j_next   = j_reg + CW'(1);
                end else begin
                    clean_next      = count_reg;
                    complete_next   = 1'b0;
                    res_status_next = ST_OK;
                    res_slot_next   = '0;
                    res_wr_next     = 1'b0;
                    state_next      = S_OUT;
                end
            end

            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = TDATA_OUT_W'({
                        complete_reg,
                        CNT_OUT_W'(clean_reg),
                        CNT_OUT_W'(count_reg),
                        res_wr_reg,
                        SLOT_OUT_W'(res_slot_reg)
                    });
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            clean_reg    <= '0;
            complete_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            pend_reg     <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            clean_reg    <= clean_next;
            complete_reg <= complete_next;
            m_tvalid_reg <= m_tvalid_next;
            pend_reg     <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        key_reg        <= key_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        hit_reg        <= hit_next;
        slot_reg       <= slot_next;
        pos_reg        <= pos_next;
        j_reg          <= j_next;
        dst_reg        <= dst_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_wr_reg     <= res_wr_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    // Memories: one write and one registered read each per cycle.
    always_ff @(posedge aclk) begin
        if (ord_we) begin
            order_mem[ord_waddr] <= ord_wdata;
        end
        order_q <= order_mem[ord_raddr];
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[slot_reg] <= key_reg;
        end
        key_q <= key_mem[key_raddr];
    end

    always_ff @(posedge aclk) begin
        if (wb_we) begin
            wb_mem[wb_waddr] <= wb_wdata;
        end
        wb_q <= wb_mem[slot_reg];
    end

    // The entry count never passes the table size.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_COUNT)
        else $error("entry count beyond table size");

    // Unwritten entries can never outnumber the allocated ones.
    a_clean_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        clean_reg <= count_reg)
        else $error("clean count above entry count");

    // The complete flag only stands while the clean count is zero.
    a_complete_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        complete_reg |-> (clean_reg == '0))
        else $error("complete flag with entries still clean");

    // A full report is only ever given for a full table.
    a_full_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_tuser_reg == ST_FULL) |-> (count_reg == MAX_COUNT))
        else $error("full status on a table with free slots");

    // The insertion shift only ever leaves towards placing the new entry.
    a_shift_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SHIFT) |=> (state_reg == S_SHIFT || state_reg == S_PLACE))
        else $error("order list shift left early");

endmodule

`default_nettype wire

@@ rtl/core/sidt_step_unit.sv @@
// Shared search step unit: midpoint of the current window, key compare and
// the narrowed window bounds. Depends on sidt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sidt_step_unit
    import sidt_pkg::*;
#(
    parameter int CW       = 7,
    parameter int KEY_BITS = 16
) (
    input  wire logic [CW-1:0]       lo,
    input  wire logic [CW-1:0]       hi,
    input  wire logic [KEY_BITS-1:0] probe_key,
    input  wire logic [KEY_BITS-1:0] target_key,
    output logic [CW-1:0]            mid,
    output logic [CW-1:0]            lo_new,
    output logic [CW-1:0]            hi_new,
    output cmp_flags_t               flags
);

    logic [CW-1:0] span;

    assign span = hi - lo;
    assign mid  = lo + (span >> 1);

    always_comb begin
        flags.in_range = (lo < hi);
        flags.hit      = (probe_key == target_key);
        flags.below    = (probe_key < target_key);
        if (flags.below) begin
            lo_new = mid + CW'(1);
            hi_new = hi;
        end else begin
            lo_new = lo;
            hi_new = mid;
        end
    end

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the sorted key table: it drives key operations
// on the input stream and checks every result against a behavioural table.
// Depends on sidt_pkg and the sorted_id_table_with_completion RTL.
`timescale 1ns / 1ps

module tb_top
    import sidt_pkg::*;
();

    localparam int TABLE_DEPTH = 64;

    // One expected result, one member per field of the result transfer.
    typedef struct packed {
        logic [1:0] status;
        logic [5:0] slot;
        logic       was_written;
        logic [6:0] entry_total;
        logic [6:0] clean_left;
        logic       frame_complete;
    } table_result_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [KEY_IN_W-1:0]    s_tdata  = '0;
    logic [1:0]             s_tuser  = MODE_ALLOC;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic [1:0]             m_tuser;

    // Behavioural copy of the table held by the block.
    logic [15:0]   tbl_keys [TABLE_DEPTH];
    bit            tbl_written [TABLE_DEPTH];
    int            tbl_entries = 0;
    int            tbl_clean = 0;
    bit            tbl_complete = 1'b0;

    table_result_t pending_results[$];
    int            errors = 0;
    int            items_sent = 0;
    int            results_checked = 0;
    int            full_reports = 0;
    int            completions = 0;
    bit            src_quiet = 1'b0;
    bit            sink_quiet = 1'b0;
    int            sink_stall = 0;

    sorted_id_table_with_completion dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #(20_000_000);
        $display("sorted_id_table_with_completion: mismatch");
        $finish;
    end

    // Mostly short gaps, now and then a long one; none at all in a quiet stretch.
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int find_slot(input logic [15:0] k);
        for (int i = 0; i < tbl_entries; i++)
            if (tbl_keys[i] == k) return i;
        return -1;
    endfunction

    function automatic logic [15:0] known_key();
        if (tbl_entries == 0) return 16'($urandom_range(0, 65535));
        return tbl_keys[$urandom_range(0, tbl_entries - 1)];
    endfunction

    // A key not in the table: corner values, near neighbours of stored keys
    // (so insertions land right beside them) or anything at all.
    function automatic logic [15:0] fresh_key();
        logic [15:0] k;
        int r;
        do begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                case ($urandom_range(0, 5))
                    0: k = 16'h0000;
                    1: k = 16'hFFFF;
                    2: k = 16'h8000;
                    3: k = 16'h7FFF;
                    4: k = 16'h0001;
                    default: k = 16'hFFFE;
                endcase
            end else if (r < 30) begin
                k = known_key() + 16'($urandom_range(1, 3));
                if ($urandom_range(0, 1) == 0) k = k - 16'd4;
            end else begin
                k = 16'($urandom_range(0, 65535));
            end
        end while (find_slot(k) >= 0);
        return k;
    endfunction

    // Applies one operation to the behavioural table and returns its result.
    task automatic model_table_op(input logic [1:0] mode, input logic [15:0] key,
                                  output table_result_t res);
        int hit_slot;
        res = '0;
        res.status = ST_OK;
        if (mode == MODE_NEWF) begin
            for (int i = 0; i < TABLE_DEPTH; i++) tbl_written[i] = 1'b0;
            tbl_clean = tbl_entries;
            tbl_complete = 1'b0;
        end else begin
            hit_slot = find_slot(key);
            if (mode == MODE_ALLOC) begin
                if (hit_slot < 0) begin
                    if (tbl_entries >= TABLE_DEPTH) begin
                        res.status = ST_FULL;
                    end else begin
                        hit_slot = tbl_entries;
                        tbl_keys[hit_slot] = key;
                        tbl_written[hit_slot] = 1'b0;
                        tbl_entries++;
                    end
                end
            end else if (hit_slot < 0) begin
                res.status = ST_ABSENT;
            end else if (mode == MODE_MARK && !tbl_written[hit_slot]) begin
                // The clean count saturates at zero; completion follows zero.
                tbl_written[hit_slot] = 1'b1;
                if (tbl_clean > 0) tbl_clean--;
                if (tbl_clean == 0) tbl_complete = 1'b1;
            end
            if (res.status == ST_OK) begin
                res.slot = 6'(hit_slot);
                res.was_written = tbl_written[hit_slot];
            end
        end
        res.entry_total = 7'(tbl_entries);
        res.clean_left = 7'(tbl_clean);
        res.frame_complete = tbl_complete;
        if (res.status == ST_FULL) full_reports++;
        if (mode == MODE_MARK && res.frame_complete) completions++;
    endtask

    // Offers one operation and waits for its transfer. Valid stays high after
    // the transfer so that a back-to-back item needs no second assignment.
    task automatic send_op(input logic [1:0] mode, input logic [15:0] key);
        int gap;
        table_result_t res;
        gap = pick_gap(src_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= key;
        s_tuser <= mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        model_table_op(mode, key, res);
        pending_results.push_back(res);
        items_sent++;
        if ($urandom_range(0, 99) == 0) src_quiet = !src_quiet;
    endtask

    // New frame, then every stored key marked in a shuffled order so that the
    // frame runs to completion, with lookups mixed in and one late re-mark.
    task automatic frame_sweep();
        int order[$];
        int j;
        int tmp;
        for (int i = 0; i < tbl_entries; i++) order.push_back(i);
        for (int i = order.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        send_op(MODE_NEWF, 16'($urandom_range(0, 65535)));
        foreach (order[i]) begin
            send_op(MODE_MARK, tbl_keys[order[i]]);
            if ($urandom_range(0, 4) == 0) send_op(MODE_LOOKUP, known_key());
        end
        send_op(MODE_MARK, known_key());
    endtask

    task automatic random_op(input int alloc_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < alloc_pct)           send_op(MODE_ALLOC, fresh_key());
        else if (r < alloc_pct + 8)  send_op(MODE_ALLOC, known_key());
        else if (r < alloc_pct + 45) send_op(MODE_MARK, known_key());
        else if (r < alloc_pct + 52) send_op(MODE_MARK, fresh_key());
        else if (r < alloc_pct + 67) send_op(MODE_LOOKUP, known_key());
        else if (r < 94)             send_op(MODE_LOOKUP, fresh_key());
        else if (r < 98)             send_op(MODE_NEWF, 16'($urandom_range(0, 65535)));
        else                         frame_sweep();
    endtask

    task automatic test_empty_table();
        send_op(MODE_LOOKUP, 16'h1234);
        send_op(MODE_MARK, 16'h0000);
        send_op(MODE_NEWF, 16'hFFFF);
    endtask

    task automatic test_basic_ops();
        send_op(MODE_ALLOC, 16'h8000);
        send_op(MODE_ALLOC, 16'h0000);     // goes to the front of the order
        send_op(MODE_ALLOC, 16'hFFFF);     // goes to the back
        send_op(MODE_ALLOC, 16'h8000);     // already present
        send_op(MODE_ALLOC, 16'h4000);     // goes into the middle
        send_op(MODE_LOOKUP, 16'hFFFF);
        send_op(MODE_LOOKUP, 16'h0001);
        send_op(MODE_MARK, 16'h0000);      // clean count already zero
        send_op(MODE_MARK, 16'h0000);      // already written
        send_op(MODE_NEWF, 16'h0000);
        send_op(MODE_MARK, 16'h8000);
        send_op(MODE_MARK, 16'h8000);
        send_op(MODE_MARK, 16'hFFFF);
        send_op(MODE_MARK, 16'h4000);
        send_op(MODE_MARK, 16'h0000);      // last clean entry: frame complete
        send_op(MODE_MARK, 16'h1235);
        send_op(MODE_ALLOC, 16'h2000);     // new entry leaves the clean count
        send_op(MODE_LOOKUP, 16'h2000);
        send_op(MODE_MARK, 16'h2000);
    endtask

    task automatic test_random_fill();
        repeat (300) random_op(15);
    endtask

    task automatic test_full_table();
        while (tbl_entries < TABLE_DEPTH) send_op(MODE_ALLOC, fresh_key());
        send_op(MODE_ALLOC, fresh_key());
        send_op(MODE_ALLOC, known_key());
        send_op(MODE_LOOKUP, known_key());
        frame_sweep();
    endtask

    task automatic test_random_full();
        repeat (240) random_op(10);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_table();
        test_basic_ops();
        test_random_fill();
        test_full_table();
        test_random_full();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        // An allocation with a full shift is the slowest operation.
        repeat (200) @(posedge aclk);
        $display("Run covered %0d operations with %0d results checked,", items_sent,
                 results_checked);
        $display("including %0d table-full replies and %0d marks seen with the frame complete.",
                 full_reports, completions);
        if (errors == 0)
            $display("sorted_id_table_with_completion: match");
        else
            $display("sorted_id_table_with_completion: mismatch");
        $finish;
    end

    // Result side back-pressure.
    always @(posedge aclk) begin
        if (sink_stall > 0) begin
            m_tready <= 1'b0;
            sink_stall--;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0) sink_stall = pick_gap(sink_quiet);
        end
        if ($urandom_range(0, 999) < 3) sink_quiet = !sink_quiet;
    end

    function automatic void check_field(input string what, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
        end
    endfunction

    always @(posedge aclk) begin : result_check
        table_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, tuser %0d tdata %h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                check_field("status", want.status, m_tuser);
                check_field("slot", want.slot, m_tdata[5:0]);
                check_field("was_written", want.was_written, m_tdata[6]);
                check_field("entry_total", want.entry_total, m_tdata[13:7]);
                check_field("clean_left", want.clean_left, m_tdata[20:14]);
                check_field("frame_complete", want.frame_complete, m_tdata[21]);
                check_field("tdata padding", 0, m_tdata[23:22]);
            end
        end
    end

endmodule

@@ files.f @@
rtl/core/sidt_pkg.sv
rtl/core/sidt_step_unit.sv
rtl/core/sorted_id_table_with_completion.sv
sim/tb_top.sv
